// ===== design/lcr_pkg.sv =====
// Shared types, codes and constants for the load-cell reader.
`default_nettype none
package lcr_pkg;

    // Default converter sample width
    localparam int SAMPLE_BITS_DEF = 24;
    // Width of the stored, sign-extended sample
    localparam int STORE_W = 32;
    // Width of the sample value port
    localparam int VALUE_W = 24;

    // Item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BUS  = 1'b1;

    // Bus event codes
    localparam logic [2:0] BUS_ADDR_WR = 3'd0;
    localparam logic [2:0] BUS_RX_BYTE = 3'd1;
    localparam logic [2:0] BUS_TX_NEXT = 3'd2;
    localparam logic [2:0] BUS_TX_END  = 3'd3;
    localparam logic [2:0] BUS_OTHER   = 3'd4;

    // Motor command bytes
    localparam logic [7:0] CMD_UP   = 8'h55;  // 'U'
    localparam logic [7:0] CMD_DOWN = 8'h44;  // 'D'
    localparam logic [7:0] CMD_STOP = 8'h53;  // 'S'

    // H-bridge drive codes: bit 0 = in1, bit 1 = in2
    localparam logic [1:0] DRV_OFF   = 2'd0;
    localparam logic [1:0] DRV_RAISE = 2'd1;
    localparam logic [1:0] DRV_LOWER = 2'd2;

    // Converter read sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    // Converter side of one result word
    typedef struct packed {
        logic               sck_level;
        logic               sample_valid;
        logic [VALUE_W-1:0] sample_value;
    } adc_res_t;

    // Bus side of one result word
    typedef struct packed {
        logic       motor_in1;
        logic       motor_in2;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } bus_res_t;

endpackage
`default_nettype wire

// ===== design/load_cell_reader_i2c_slave.sv =====
// Top level of the load-cell reader with bus slave and motor control.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_ready  | opcode, dt_level, bus_status, bus_data
//   out     | out_valid/out_ready| sck_level, motor_in1, motor_in2, tx_byte,
//           |                    | tx_valid, sample_valid, sample_value
//
// Each word gives one result word after it is taken, passing through the input
// register and then the result register. One word per cycle is sustained while the
// output is not stalled; the state update sits between the two registers.
// Reset clears the sequencer, stored sample, byte index and motor drive state.
// A stalled output holds the result register and then the input register.
`default_nettype none
module load_cell_reader_i2c_slave #(
    parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                opcode,
    input  wire logic                                dt_level,
    input  wire logic [2:0]                          bus_status,
    input  wire logic [7:0]                          bus_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     sck_level,
    output logic                                     motor_in1,
    output logic                                     motor_in2,
    output logic [7:0]                               tx_byte,
    output logic                                     tx_valid,
    output logic                                     sample_valid,
    output logic signed [lcr_pkg::VALUE_W-1:0]       sample_value
);

    logic                           s1_valid_reg;
    logic                           s1_opcode_reg;
    logic                           s1_dt_reg;
    logic [2:0]                     s1_status_reg;
    logic [7:0]                     s1_data_reg;
    logic                           s1_adv;
    logic                           step;
    logic                           out_valid_reg;
    lcr_pkg::adc_res_t              adc_res;
    lcr_pkg::bus_res_t              bus_res;
    lcr_pkg::adc_res_t              adc_out_reg;
    lcr_pkg::bus_res_t              bus_out_reg;
    logic [lcr_pkg::STORE_W-1:0]    stored_sample;

    // Move words forward whenever the result register frees up
    assign s1_adv   = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_opcode_reg <= opcode;
            s1_dt_reg     <= dt_level;
            s1_status_reg <= bus_status;
            s1_data_reg   <= bus_data;
        end
    end

    lcr_adc_seq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_adc (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .opcode        (s1_opcode_reg),
        .dt_level      (s1_dt_reg),
        .res           (adc_res),
        .stored_sample (stored_sample)
    );

    lcr_bus_srv u_bus (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .opcode        (s1_opcode_reg),
        .bus_status    (s1_status_reg),
        .bus_data      (s1_data_reg),
        .stored_sample (stored_sample),
        .res           (bus_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            adc_out_reg <= adc_res;
            bus_out_reg <= bus_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sck_level    = adc_out_reg.sck_level;
    assign sample_valid = adc_out_reg.sample_valid;
    assign sample_value = signed'(adc_out_reg.sample_value);
    assign motor_in1    = bus_out_reg.motor_in1;
    assign motor_in2    = bus_out_reg.motor_in2;
    assign tx_byte      = bus_out_reg.tx_byte;
    assign tx_valid     = bus_out_reg.tx_valid;

`ifndef SYNTH
    // A tick and a bus event never report in the same word
    a_excl_events: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tx_valid && sample_valid))
        else $error("tx_valid and sample_valid together");

    // A finished sample leaves the converter clock low
    a_done_clk_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_valid) |-> !sck_level)
        else $error("sample completed with clock high");

    // The H-bridge is never driven both ways
    a_motor_safe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(motor_in1 && motor_in2))
        else $error("both motor pins high");

    // Bytes not loaded for transmit read as zero
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_valid) |-> (tx_byte == 8'd0))
        else $error("tx_byte nonzero without tx_valid");
`endif

endmodule
`default_nettype wire

// ===== design/lcr_adc_seq.sv =====
// Converter read sequencer: clock pulses, bit shifting and sample storage.
`default_nettype none
module lcr_adc_seq #(
    parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          opcode,
    input  wire logic                          dt_level,
    output lcr_pkg::adc_res_t                  res,
    output logic [lcr_pkg::STORE_W-1:0]        stored_sample
);

    localparam int PCNT_W = $clog2(SAMPLE_BITS + 2);
    localparam logic [PCNT_W-1:0] LAST_PULSE = PCNT_W'(SAMPLE_BITS + 1);

    lcr_pkg::phase_t                phase_reg, phase_next;
    logic [PCNT_W-1:0]              pulse_reg, pulse_next;
    logic [SAMPLE_BITS-1:0]         shift_reg, shift_next;
    logic [lcr_pkg::STORE_W-1:0]    store_reg, store_next;
    logic                           done;

    // Advance the read sequence on each clock tick
    always_comb
    begin
        phase_next = phase_reg;
        pulse_next = pulse_reg;
        shift_next = shift_reg;
        store_next = store_reg;
        done       = 1'b0;
        if (opcode == lcr_pkg::OP_TICK)
        begin
            unique case (phase_reg)
                lcr_pkg::PH_HIGH:
                begin
                    if (pulse_reg >= LAST_PULSE)
                    begin
                        store_next = lcr_pkg::STORE_W'(signed'(shift_reg));
                        done       = 1'b1;
                        phase_next = lcr_pkg::PH_IDLE;
                        pulse_next = '0;
                    end
                    else
                    begin
                        phase_next = lcr_pkg::PH_LOW;
                    end
                end
                lcr_pkg::PH_LOW:
                begin
                    shift_next = {shift_reg[SAMPLE_BITS-2:0], dt_level};
                    pulse_next = pulse_reg + PCNT_W'(1);
                    phase_next = lcr_pkg::PH_HIGH;
                end
                default:
                begin
                    // Wait in idle until the converter pulls data low
                    phase_next = lcr_pkg::PH_IDLE;
                    if (!dt_level)
                    begin
                        shift_next = '0;
                        pulse_next = PCNT_W'(1);
                        phase_next = lcr_pkg::PH_HIGH;
                    end
                end
            endcase
        end
    end

    // Hold sequencer state between accepted words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lcr_pkg::PH_IDLE;
            pulse_reg <= '0;
            shift_reg <= '0;
            store_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pulse_reg <= pulse_next;
            shift_reg <= shift_next;
            store_reg <= store_next;
        end
    end

    // Report pin level and sample after this word
    always_comb
    begin
        res.sck_level    = (phase_next == lcr_pkg::PH_HIGH);
        res.sample_valid = done;
        res.sample_value = store_next[lcr_pkg::VALUE_W-1:0];
    end

    assign stored_sample = store_reg;

endmodule
`default_nettype wire

// ===== design/lcr_bus_srv.sv =====
// Bus slave service: motor commands and byte-wise sample readout.
`default_nettype none
module lcr_bus_srv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          opcode,
    input  wire logic [2:0]                    bus_status,
    input  wire logic [7:0]                    bus_data,
    input  wire logic [lcr_pkg::STORE_W-1:0]   stored_sample,
    output lcr_pkg::bus_res_t                  res
);

    logic [1:0] motor_reg, motor_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] tx_byte;
    logic       tx_valid;

    // Decode bus events
    always_comb
    begin
        motor_next = motor_reg;
        idx_next   = idx_reg;
        tx_byte    = 8'd0;
        tx_valid   = 1'b0;
        if (opcode == lcr_pkg::OP_BUS)
        begin
            unique case (bus_status)
                lcr_pkg::BUS_RX_BYTE:
                begin
                    priority if (bus_data == lcr_pkg::CMD_UP)
                        motor_next = lcr_pkg::DRV_RAISE;
                    else if (bus_data == lcr_pkg::CMD_DOWN)
                        motor_next = lcr_pkg::DRV_LOWER;
                    else if (bus_data == lcr_pkg::CMD_STOP)
                        motor_next = lcr_pkg::DRV_OFF;
                    else
                        motor_next = motor_reg;
                end
                lcr_pkg::BUS_TX_NEXT:
                begin
                    tx_byte  = stored_sample[{idx_reg, 3'b000} +: 8];
                    tx_valid = 1'b1;
                    idx_next = idx_reg + 2'd1;
                end
                lcr_pkg::BUS_TX_END:
                begin
                    idx_next = 2'd0;
                end
                default:
                begin
                    // Addressed write and other events leave state alone
                    idx_next = idx_reg;
                end
            endcase
        end
    end

    // Hold motor drive and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg <= lcr_pkg::DRV_OFF;
            idx_reg   <= 2'd0;
        end
        else if (step)
        begin
            motor_reg <= motor_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        res.motor_in1 = motor_next[0];
        res.motor_in2 = motor_next[1];
        res.tx_byte   = tx_byte;
        res.tx_valid  = tx_valid;
    end

endmodule
`default_nettype wire

// ===== tb/load_cell_reader_i2c_slave_tb.sv =====
// Self-checking testbench for the load-cell reader with bus slave and motor control.

localparam int SBITS = lcr_pkg::SAMPLE_BITS_DEF;
localparam logic [31:0] SMASK = (SBITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SBITS) - 32'd1);

// One input word as driven on the ports
typedef struct packed {
    logic       op;
    logic       dt;
    logic [2:0] status;
    logic [7:0] data;
} req_word_t;

// One result word as seen on the ports
typedef struct packed {
    logic                        sck;
    logic                        in1;
    logic                        in2;
    logic [7:0]                  tx_byte;
    logic                        tx_valid;
    logic                        smp_valid;
    logic [lcr_pkg::VALUE_W-1:0] smp_value;
} rsp_word_t;

// Tracks converter sequencer, stored sample, byte index and motor pins
class load_cell_scoreboard;
    lcr_pkg::phase_t rd_phase = lcr_pkg::PH_IDLE;
    logic [5:0]      pulses = '0;
    logic [31:0]     shift_reg = '0;
    logic [31:0]     held_sample = '0;
    logic [1:0]      byte_idx = '0;
    logic [1:0]      drive = lcr_pkg::DRV_OFF;
    rsp_word_t       expected_q[$];
    int              errors = 0;

    // Advance the state by one accepted word and queue the result it gives
    function void note_word(req_word_t w);
        rsp_word_t   r;
        logic [31:0] raw;
        r = '0;
        if (w.op == lcr_pkg::OP_TICK) begin
            case (rd_phase)
                lcr_pkg::PH_HIGH:
                begin
                    if (pulses >= 6'(SBITS + 1)) begin
                        raw = shift_reg & SMASK;
                        if (raw[SBITS-1])
                            raw = raw | ~SMASK;
                        held_sample = raw;
                        r.smp_valid = 1'b1;
                        rd_phase = lcr_pkg::PH_IDLE;
                        pulses = '0;
                    end else begin
                        rd_phase = lcr_pkg::PH_LOW;
                    end
                end
                lcr_pkg::PH_LOW:
                begin
                    shift_reg = {shift_reg[30:0], w.dt} & SMASK;
                    pulses = pulses + 6'd1;
                    rd_phase = lcr_pkg::PH_HIGH;
                end
                default:
                begin
                    // idle: a low data pin means the converter is ready
                    rd_phase = lcr_pkg::PH_IDLE;
                    if (!w.dt) begin
                        shift_reg = '0;
                        pulses = 6'd1;
                        rd_phase = lcr_pkg::PH_HIGH;
                    end
                end
            endcase
        end else begin
            case (w.status)
                lcr_pkg::BUS_RX_BYTE:
                begin
                    if (w.data == lcr_pkg::CMD_UP)
                        drive = lcr_pkg::DRV_RAISE;
                    else if (w.data == lcr_pkg::CMD_DOWN)
                        drive = lcr_pkg::DRV_LOWER;
                    else if (w.data == lcr_pkg::CMD_STOP)
                        drive = lcr_pkg::DRV_OFF;
                end
                lcr_pkg::BUS_TX_NEXT:
                begin
                    r.tx_byte = held_sample[byte_idx*8 +: 8];
                    r.tx_valid = 1'b1;
                    byte_idx = byte_idx + 2'd1;
                end
                lcr_pkg::BUS_TX_END:
                begin
                    byte_idx = '0;
                end
                default:
                begin
                end
            endcase
        end
        r.sck = (rd_phase == lcr_pkg::PH_HIGH);
        r.in1 = drive[0];
        r.in2 = drive[1];
        r.smp_value = held_sample[lcr_pkg::VALUE_W-1:0];
        expected_q.push_back(r);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(rsp_word_t got);
        rsp_word_t want;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result word %p", got);
            return;
        end
        want = expected_q.pop_front();
        if (got.sck !== want.sck || got.in1 !== want.in1 || got.in2 !== want.in2 ||
            got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
            got.smp_valid !== want.smp_valid || got.smp_value !== want.smp_value) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch (exp/act): sck %b/%b in1 %b/%b in2 %b/%b tx_byte %h/%h",
                         want.sck, got.sck, want.in1, got.in1, want.in2, got.in2,
                         want.tx_byte, got.tx_byte);
                $display("    tx_valid %b/%b sample_valid %b/%b sample_value %h/%h",
                         want.tx_valid, got.tx_valid, want.smp_valid, got.smp_valid,
                         want.smp_value, got.smp_value);
            end
        end
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction
endclass

module load_cell_reader_i2c_slave_tb;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               opcode;
    logic                               dt_level;
    logic [2:0]                         bus_status;
    logic [7:0]                         bus_data;
    logic                               out_valid;
    logic                               out_ready;
    logic                               sck_level;
    logic                               motor_in1;
    logic                               motor_in2;
    logic [7:0]                         tx_byte;
    logic                               tx_valid;
    logic                               sample_valid;
    logic signed [lcr_pkg::VALUE_W-1:0] sample_value;

    load_cell_scoreboard sb;
    req_word_t           stim_q[$];
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_left = 0;

    load_cell_reader_i2c_slave uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .dt_level     (dt_level),
        .bus_status   (bus_status),
        .bus_data     (bus_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sck_level    (sck_level),
        .motor_in1    (motor_in1),
        .motor_in2    (motor_in2),
        .tx_byte      (tx_byte),
        .tx_valid     (tx_valid),
        .sample_valid (sample_valid),
        .sample_value (sample_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Drive out_ready: a long hold when asked, else random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check every accepted result word
    initial
    begin
        rsp_word_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got = {sck_level, motor_in1, motor_in2, tx_byte, tx_valid,
                       sample_valid, sample_value};
                sb.check_word(got);
            end
        end
    end

    task automatic push_word(input logic op, input logic dt, input logic [2:0] st,
                             input logic [7:0] d);
        req_word_t w;
        w.op = op;
        w.dt = dt;
        w.status = st;
        w.data = d;
        stim_q.push_back(w);
    endtask

    // Converter tick; bus fields are ignored so fill them with noise
    task automatic push_tick(input logic dt);
        push_word(lcr_pkg::OP_TICK, dt, 3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    // Random bus event, biased toward transmits and motor commands
    task automatic push_bus_event();
        int         pick;
        logic [2:0] st;
        logic [7:0] d;
        pick = $urandom_range(99);
        d = 8'($urandom_range(255));
        if (pick < 30) begin
            st = lcr_pkg::BUS_TX_NEXT;
        end else if (pick < 40) begin
            st = lcr_pkg::BUS_TX_END;
        end else if (pick < 65) begin
            st = lcr_pkg::BUS_RX_BYTE;
            case ($urandom_range(3))
                0: d = lcr_pkg::CMD_UP;
                1: d = lcr_pkg::CMD_DOWN;
                2: d = lcr_pkg::CMD_STOP;
                default: ;
            endcase
        end else begin
            st = 3'($urandom_range(7));
        end
        push_word(lcr_pkg::OP_BUS, 1'($urandom_range(1)), st, d);
    endtask

    task automatic maybe_bus_event();
        if ($urandom_range(99) < 15)
            push_bus_event();
    endtask

    // Full converter read of one chosen sample, bus events mixed in
    task automatic push_read();
        logic [31:0] value;
        case ($urandom_range(9))
            0: value = 32'h0080_0000;
            1: value = 32'h007F_FFFF;
            2: value = 32'h0000_0000;
            3: value = 32'h00FF_FFFF;
            default: value = $urandom & SMASK;
        endcase
        repeat ($urandom_range(3)) push_tick(1'b1);
        maybe_bus_event();
        push_tick(1'b0);
        for (int i = SBITS - 1; i >= 0; i--) begin
            maybe_bus_event();
            push_tick(1'($urandom_range(1)));
            maybe_bus_event();
            push_tick(value[i]);
        end
        maybe_bus_event();
        push_tick(1'($urandom_range(1)));
    endtask

    // Ticks with data high: finish any read in progress, then wait in idle
    task automatic push_flush();
        repeat (2 * SBITS + 2) push_tick(1'b1);
    endtask

    task automatic gen_traffic(input int count);
        int target;
        int pick;
        target = stim_q.size() + count;
        while (stim_q.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                push_read();
            end else if (pick < 88) begin
                repeat ($urandom_range(3, 10)) push_bus_event();
            end else begin
                // broken read: random ticks, then flush back to idle
                repeat ($urandom_range(1, 8)) push_tick(1'($urandom_range(1)));
                push_flush();
            end
        end
    endtask

    // Offer one word, with random idle cycles ahead of it, until it is taken
    task automatic drive_word(input req_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= w.op;
        dt_level <= w.dt;
        bus_status <= w.status;
        bus_data <= w.data;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(w);
    endtask

    // Send everything queued, then hold off until all results are back
    task automatic run_queue();
        while (stim_q.size() > 0)
            drive_word(stim_q.pop_front());
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = lcr_pkg::OP_TICK;
        dt_level = 1'b1;
        bus_status = lcr_pkg::BUS_ADDR_WR;
        bus_data = 8'h00;
        out_ready = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: motor commands, odd bytes, every bus code, byte wrap, read start
        push_word(lcr_pkg::OP_BUS, 1'b0, lcr_pkg::BUS_RX_BYTE, lcr_pkg::CMD_UP);
        push_word(lcr_pkg::OP_BUS, 1'b1, lcr_pkg::BUS_RX_BYTE, 8'h00);
        push_word(lcr_pkg::OP_BUS, 1'b0, lcr_pkg::BUS_RX_BYTE, lcr_pkg::CMD_DOWN);
        push_word(lcr_pkg::OP_BUS, 1'b1, lcr_pkg::BUS_RX_BYTE, 8'hFF);
        push_word(lcr_pkg::OP_BUS, 1'b0, lcr_pkg::BUS_RX_BYTE, lcr_pkg::CMD_STOP);
        push_word(lcr_pkg::OP_BUS, 1'b1, lcr_pkg::BUS_RX_BYTE, lcr_pkg::CMD_UP);
        push_word(lcr_pkg::OP_BUS, 1'b1, lcr_pkg::BUS_ADDR_WR, 8'hFF);
        push_word(lcr_pkg::OP_BUS, 1'b0, lcr_pkg::BUS_OTHER, lcr_pkg::CMD_DOWN);
        for (int k = 1; k <= 3; k++)
            push_word(lcr_pkg::OP_BUS, 1'b1, 3'(lcr_pkg::BUS_OTHER + k), lcr_pkg::CMD_STOP);
        repeat (5) push_word(lcr_pkg::OP_BUS, 1'b0, lcr_pkg::BUS_TX_NEXT, 8'hFF);
        push_word(lcr_pkg::OP_BUS, 1'b1, lcr_pkg::BUS_TX_END, 8'h00);
        push_word(lcr_pkg::OP_BUS, 1'b0, lcr_pkg::BUS_TX_NEXT, 8'h00);
        push_word(lcr_pkg::OP_TICK, 1'b1, lcr_pkg::BUS_TX_NEXT, 8'h00);
        push_word(lcr_pkg::OP_TICK, 1'b0, 3'(lcr_pkg::BUS_OTHER + 3), 8'hFF);
        push_word(lcr_pkg::OP_TICK, 1'b1, lcr_pkg::BUS_RX_BYTE, lcr_pkg::CMD_DOWN);
        push_word(lcr_pkg::OP_BUS, 1'b0, lcr_pkg::BUS_TX_NEXT, 8'h00);
        push_word(lcr_pkg::OP_BUS, 1'b1, lcr_pkg::BUS_RX_BYTE, lcr_pkg::CMD_DOWN);
        push_word(lcr_pkg::OP_TICK, 1'b1, lcr_pkg::BUS_ADDR_WR, 8'h00);
        push_flush();
        run_queue();

        // No idling, with one long receiver hold so the input backs up
        gen_traffic(80);
        hold_left = 150;
        run_queue();

        send_idle_pct = 45;
        stall_pct = 0;
        gen_traffic(140);
        run_queue();

        send_idle_pct = 0;
        stall_pct = 45;
        gen_traffic(140);
        run_queue();

        send_idle_pct = 26;
        stall_pct = 26;
        gen_traffic(140);
        run_queue();

        // Let any stray result word show up
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
